// File: sv/assert_macros.svh
// Assertion macros for the RTL of the small matrix unit.
// Expect clk and rst in scope; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/smat_pkg.sv
// Shared codes and token control type for the small matrix unit.
// No dependencies.
package smat_pkg;

  typedef enum logic [1:0] {
    REQ_WR_A = 2'd0,
    REQ_WR_B = 2'd1,
    REQ_RUN  = 2'd2
  } req_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_TRN = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_SIZE    = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OP     = 3'd4;

  typedef struct packed {
    logic valid;
    logic do_mul;
    logic do_add;
    logic first;
    logic emit;
    logic last;
  } tok_ctl_t;

endpackage

// File: sv/smat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/smat_cell.sv
// One column cell: holds one column of B and a local accumulator, two stages deep.
// Depends on smat_pkg.
module smat_cell import smat_pkg::*; #(
  parameter int CELL_ID    = 0,
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          b_we,
  input  logic [$clog2(MAX_DIM)-1:0]    b_row,
  input  logic [$clog2(MAX_DIM)-1:0]    b_col,
  input  logic [DATA_WIDTH-1:0]         b_data,
  input  tok_ctl_t                      in_ctl,
  input  logic [DATA_WIDTH-1:0]         in_data,
  input  logic [$clog2(MAX_DIM)-1:0]    in_baddr,
  input  logic [$clog2(MAX_DIM)-1:0]    in_col,
  input  logic [$clog2(MAX_DIM)-1:0]    in_orow,
  input  logic [$clog2(MAX_DIM)-1:0]    in_ocol,
  output tok_ctl_t                      out_ctl,
  output logic [DATA_WIDTH-1:0]         out_data,
  output logic [$clog2(MAX_DIM)-1:0]    out_baddr,
  output logic [$clog2(MAX_DIM)-1:0]    out_col,
  output logic [$clog2(MAX_DIM)-1:0]    out_orow,
  output logic [$clog2(MAX_DIM)-1:0]    out_ocol
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DEPTH = 1 << IDX_W;
  localparam logic [IDX_W-1:0] MY_COL = IDX_W'(CELL_ID);

  logic [DATA_WIDTH-1:0] bcol [DEPTH];
  logic [DEPTH-1:0]      bvalid;

  tok_ctl_t              ctl1;
  logic [DATA_WIDTH-1:0] data1;
  logic [DATA_WIDTH-1:0] opnd1;
  logic [IDX_W-1:0]      baddr1;
  logic [IDX_W-1:0]      col1;
  logic [IDX_W-1:0]      orow1;
  logic [IDX_W-1:0]      ocol1;
  logic                  hit1;
  logic [DATA_WIDTH-1:0] acc;

  logic [DATA_WIDTH-1:0] b_rd;
  logic [DATA_WIDTH-1:0] prod;
  logic                  hit;
  logic [DATA_WIDTH-1:0] acc_next;

  assign b_rd     = bvalid[in_baddr] ? bcol[in_baddr] : '0;
  assign prod     = in_data * b_rd;
  assign hit      = in_ctl.valid && (in_ctl.do_mul || in_ctl.do_add) && (in_col == MY_COL);
  assign acc_next = (ctl1.first ? '0 : acc) + opnd1;

  // column store of B
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (b_we && b_col == MY_COL) begin
      bvalid[b_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we && b_col == MY_COL) begin
      bcol[b_row] <= b_data;
    end
  end

  // stage one: fetch B and, for a multiply token, form the product
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      hit1 <= 1'b0;
    end else begin
      ctl1 <= in_ctl;
      hit1 <= hit;
    end
  end

  always_ff @(posedge clk) begin
    data1  <= in_data;
    opnd1  <= in_ctl.do_mul ? prod : b_rd;
    baddr1 <= in_baddr;
    col1   <= in_col;
    orow1  <= in_orow;
    ocol1  <= in_ocol;
  end

  // stage two: accumulate or add, hand on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit1 && ctl1.do_mul) begin
      acc <= acc_next;
    end
    if (hit1 && ctl1.do_mul) begin
      out_data <= acc_next;
    end else if (hit1 && ctl1.do_add) begin
      out_data <= data1 + opnd1;
    end else begin
      out_data <= data1;
    end
    out_baddr <= baddr1;
    out_col   <= col1;
    out_orow  <= orow1;
    out_ocol  <= ocol1;
  end

endmodule

// File: sv/small_matrix_add_multiply_transpose.sv
// Small integer matrix unit: element writes into A and B, then add, multiply or transpose A.
// A rejected write or a size mismatch gives its single result in the cycle after the request. A
// run holds busy high while elements stream from the A RAM, one per cycle, into a chain of
// MAX_DIM column cells (each holds one column of B, one multiplier and an accumulator). Add and
// transpose feed ra*ca elements, multiply ra*cb*ca elements; results pass through the read
// register, the cell chain and the result register, at most one per cycle, each shown for one
// cycle on out_strobe. There is no back-pressure: the receiver must take every strobed result.
// Depends on smat_pkg, smat_ram, smat_cell and assert_macros.svh.
`include "assert_macros.svh"
module small_matrix_add_multiply_transpose import smat_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [2:0]            row_index,
  input  logic [2:0]            col_index,
  input  logic signed [31:0]    elem_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic [2:0]            out_row,
  output logic [2:0]            out_col,
  output logic signed [31:0]    out_value,
  output logic [1:0]            status,
  output logic                  is_last
);

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W   = DIM_W + 3;
  localparam int A_AW    = 2 * IDX_W;
  localparam int A_DEPTH = 1 << A_AW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FEED = 2'b10
  } state_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

  logic [CFG_DATA_W-1:0] rows_first, cols_first, rows_second, cols_second;
  logic [1:0]            op_mode;

  state_t           state;
  logic             drain;
  logic [IDX_W-1:0] c0, c1, c2;
  logic [IDX_W-1:0] l0m1, l1m1, l2m1;
  logic             m_add, m_mul;

  logic [A_DEPTH-1:0] a_valid;
  logic               a_hit_q;
  logic [DATA_WIDTH-1:0] a_q;

  tok_ctl_t         p_ctl;
  logic [IDX_W-1:0] p_baddr, p_col, p_orow, p_ocol;

  logic [DIM_W-1:0] ra, ca, rb, cb;
  logic             accept, is_wr_a, is_wr_b, is_run, bad_pos, mismatch;
  logic             err_go, run_go, wr_a_go, wr_b_go;
  logic [DIM_W-1:0] nr, nc;
  logic [IDX_W-1:0] wr_row, wr_col;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [A_AW-1:0]  rd_addr;
  logic             feeding, feed_last, inner_last;
  tok_ctl_t         f_ctl;
  logic [IDX_W-1:0] f_baddr, f_col;
  logic [DIM_W-1:0] n_l0, n_l1, n_l2;

  tok_ctl_t              ch_ctl   [MAX_DIM+1];
  logic [DATA_WIDTH-1:0] ch_data  [MAX_DIM+1];
  logic [IDX_W-1:0]      ch_baddr [MAX_DIM+1];
  logic [IDX_W-1:0]      ch_col   [MAX_DIM+1];
  logic [IDX_W-1:0]      ch_orow  [MAX_DIM+1];
  logic [IDX_W-1:0]      ch_ocol  [MAX_DIM+1];
  logic                  tail_emit;

  assign ra = dim_of(rows_first);
  assign ca = dim_of(cols_first);
  assign rb = dim_of(rows_second);
  assign cb = dim_of(cols_second);

  assign busy    = (state != S_IDLE) || drain;
  assign accept  = start && !busy;
  assign is_wr_a = req_type == REQ_WR_A;
  assign is_wr_b = req_type == REQ_WR_B;
  assign is_run  = req_type == REQ_RUN;
  assign nr      = is_wr_a ? ra : rb;
  assign nc      = is_wr_a ? ca : cb;
  assign bad_pos = (CMP_W'(row_index) >= CMP_W'(nr)) || (CMP_W'(col_index) >= CMP_W'(nc));

  always_comb begin
    mismatch = 1'b1;
    n_l0     = ra;
    n_l1     = ca;
    n_l2     = DIM_W'(1);
    case (op_mode)
      OP_ADD: begin
        mismatch = (ra != rb) || (ca != cb);
      end
      OP_MUL: begin
        mismatch = ca != rb;
        n_l1     = cb;
        n_l2     = ca;
      end
      OP_TRN: begin
        mismatch = 1'b0;
        n_l0     = ca;
        n_l1     = ra;
      end
      default: begin
        mismatch = 1'b1;
      end
    endcase
  end

  assign err_go  = accept && (((is_wr_a || is_wr_b) && bad_pos) || (is_run && mismatch));
  assign run_go  = accept && is_run && !mismatch;
  assign wr_a_go = accept && is_wr_a && !bad_pos;
  assign wr_b_go = accept && is_wr_b && !bad_pos;
  assign wr_row  = IDX_W'(row_index);
  assign wr_col  = IDX_W'(col_index);
  assign wr_data = DATA_WIDTH'(elem_value);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_first  <= CFG_DATA_W'(8);
      cols_first  <= CFG_DATA_W'(8);
      rows_second <= CFG_DATA_W'(8);
      cols_second <= CFG_DATA_W'(8);
      op_mode     <= OP_MUL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A: rows_first  <= cfg_data;
        CFG_COLS_A: cols_first  <= cfg_data;
        CFG_ROWS_B: rows_second <= cfg_data;
        CFG_COLS_B: cols_second <= cfg_data;
        CFG_OP:     op_mode     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  assign feeding    = state == S_FEED;
  assign inner_last = c2 == l2m1;
  assign feed_last  = inner_last && (c1 == l1m1) && (c0 == l0m1);

  always_comb begin
    f_ctl.valid  = feeding;
    f_ctl.do_mul = m_mul;
    f_ctl.do_add = m_add;
    f_ctl.first  = c2 == '0;
    f_ctl.emit   = !m_mul || inner_last;
    f_ctl.last   = feed_last;
    if (m_mul) begin
      rd_addr = {c0, c2};
      f_baddr = c2;
      f_col   = c1;
    end else if (m_add) begin
      rd_addr = {c0, c1};
      f_baddr = c0;
      f_col   = c1;
    end else begin
      rd_addr = {c1, c0};
      f_baddr = c0;
      f_col   = c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (run_go) begin
            state <= S_FEED;
          end
        end
        S_FEED: begin
          if (feed_last) begin
            state <= S_IDLE;
            drain <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ch_ctl[MAX_DIM].valid && ch_ctl[MAX_DIM].last) begin
        drain <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_go) begin
      c0    <= '0;
      c1    <= '0;
      c2    <= '0;
      l0m1  <= IDX_W'(n_l0 - DIM_W'(1));
      l1m1  <= IDX_W'(n_l1 - DIM_W'(1));
      l2m1  <= IDX_W'(n_l2 - DIM_W'(1));
      m_add <= op_mode == OP_ADD;
      m_mul <= op_mode == OP_MUL;
    end else if (feeding) begin
      if (inner_last) begin
        c2 <= '0;
        if (c1 == l1m1) begin
          c1 <= '0;
          c0 <= c0 + IDX_W'(1);
        end else begin
          c1 <= c1 + IDX_W'(1);
        end
      end else begin
        c2 <= c2 + IDX_W'(1);
      end
    end
  end

  // store of A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= '0;
    end else if (wr_a_go) begin
      a_valid[{wr_row, wr_col}] <= 1'b1;
    end
  end

  smat_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (A_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_a_go),
    .waddr ({wr_row, wr_col}),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (a_q)
  );

  // align token with the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= f_ctl;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_q <= a_valid[rd_addr];
    p_baddr <= f_baddr;
    p_col   <= f_col;
    p_orow  <= c0;
    p_ocol  <= c1;
  end

  assign ch_ctl[0]   = p_ctl;
  assign ch_data[0]  = a_hit_q ? a_q : '0;
  assign ch_baddr[0] = p_baddr;
  assign ch_col[0]   = p_col;
  assign ch_orow[0]  = p_orow;
  assign ch_ocol[0]  = p_ocol;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    smat_cell #(
      .CELL_ID    (g),
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .b_we      (wr_b_go),
      .b_row     (wr_row),
      .b_col     (wr_col),
      .b_data    (wr_data),
      .in_ctl    (ch_ctl[g]),
      .in_data   (ch_data[g]),
      .in_baddr  (ch_baddr[g]),
      .in_col    (ch_col[g]),
      .in_orow   (ch_orow[g]),
      .in_ocol   (ch_ocol[g]),
      .out_ctl   (ch_ctl[g+1]),
      .out_data  (ch_data[g+1]),
      .out_baddr (ch_baddr[g+1]),
      .out_col   (ch_col[g+1]),
      .out_orow  (ch_orow[g+1]),
      .out_ocol  (ch_ocol[g+1])
    );
  end

  assign tail_emit = ch_ctl[MAX_DIM].valid && ch_ctl[MAX_DIM].emit;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= err_go || tail_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (err_go) begin
      out_row   <= is_run ? 3'd0 : row_index;
      out_col   <= is_run ? 3'd0 : col_index;
      out_value <= '0;
      status    <= is_run ? ST_SIZE : ST_BAD_POS;
      is_last   <= 1'b1;
    end else begin
      out_row   <= 3'(ch_orow[MAX_DIM]);
      out_col   <= 3'(ch_ocol[MAX_DIM]);
      out_value <= 32'(ch_data[MAX_DIM]);
      status    <= ST_OK;
      is_last   <= ch_ctl[MAX_DIM].last;
    end
  end

  `ASSERT_ALWAYS(a_err_is_last, !(out_strobe && status != ST_OK) || is_last)
  `ASSERT_ALWAYS(a_no_collide, !(err_go && tail_emit))
  `ASSERT_NEXT(a_feed_to_drain, feeding && feed_last, busy && state == S_IDLE)
  `ASSERT_NEXT(a_tail_last_idle, ch_ctl[MAX_DIM].valid && ch_ctl[MAX_DIM].last, !busy)

endmodule
